// File: rtl/core/pwci_pkg.sv
// Shared widths, register codes, reset values and config bundle for the PID block.
package pwci_pkg;

	localparam int ERR_WIDTH       = 24;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int GAIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 32;
	localparam int DRIVE_WIDTH     = 40;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;

	// register indexes on the config port
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_UPPER = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_LOWER = 3'd4;

	// item modes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_CLEAR  = 1'b1;

	localparam logic signed [GAIN_WIDTH-1:0]  PROP_GAIN_RST   = 16'sd256;
	localparam logic signed [GAIN_WIDTH-1:0]  INTEG_GAIN_RST  = 16'sd2560;
	localparam logic signed [GAIN_WIDTH-1:0]  DERIV_GAIN_RST  = 16'sd0;
	localparam logic signed [LIMIT_WIDTH-1:0] INTEG_UPPER_RST = 32'sd65535;
	localparam logic signed [LIMIT_WIDTH-1:0] INTEG_LOWER_RST = -32'sd65535;

	typedef struct packed {
		logic signed [GAIN_WIDTH-1:0]  prop_gain;
		logic signed [GAIN_WIDTH-1:0]  integ_gain;
		logic signed [GAIN_WIDTH-1:0]  deriv_gain;
		logic signed [LIMIT_WIDTH-1:0] integ_upper;
		logic signed [LIMIT_WIDTH-1:0] integ_lower;
	} pwci_cfg_t;

endpackage

// File: rtl/core/pwci_cfg_regs.sv
// Configuration register file: gains and integral clamp limits.
module pwci_cfg_regs
	import pwci_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	output pwci_cfg_t                  cfg
);

	pwci_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.deriv_gain  <= DERIV_GAIN_RST;
			cfg_q.integ_upper <= INTEG_UPPER_RST;
			cfg_q.integ_lower <= INTEG_LOWER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_WIDTH-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_WIDTH-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_WIDTH-1:0];
				REG_INTEG_UPPER: cfg_q.integ_upper <= cfg_data[LIMIT_WIDTH-1:0];
				REG_INTEG_LOWER: cfg_q.integ_lower <= cfg_data[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/pwci_core.sv
// Controller state and the combinational PID arithmetic for one item.
module pwci_core
	import pwci_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          mode,
	input  logic signed [ERR_WIDTH-1:0]   error_in,
	input  pwci_cfg_t                     cfg,
	output logic signed [DRIVE_WIDTH-1:0] drive_next
);

	localparam int PROD_W  = GAIN_WIDTH + ERR_WIDTH;
	localparam int ACC_W   = PROD_W + 1;
	localparam int DIFF_W  = ERR_WIDTH + 1;
	localparam int DPROD_W = GAIN_WIDTH + DIFF_W;
	localparam int SUM_W   = DPROD_W + 2;

	logic signed [ERR_WIDTH-1:0]   prev_error_q;
	logic signed [LIMIT_WIDTH-1:0] integ_acc_q;
	logic                          primed_q;

	logic signed [PROD_W-1:0]      kp_prod, kp_term;
	logic signed [PROD_W-1:0]      ki_prod, ki_term;
	logic signed [DIFF_W-1:0]      diff;
	logic signed [DPROD_W-1:0]     kd_prod, kd_term;
	logic signed [ACC_W-1:0]       acc_sum, acc_hi, acc_lim;
	logic signed [LIMIT_WIDTH-1:0] integ_next;
	logic signed [SUM_W-1:0]       total;

	always_comb begin
		kp_prod = PROD_W'(cfg.prop_gain) * PROD_W'(error_in);
		kp_term = kp_prod >>> GAIN_FRAC_BITS;
		ki_prod = PROD_W'(cfg.integ_gain) * PROD_W'(error_in);
		ki_term = ki_prod >>> GAIN_FRAC_BITS;
		diff    = DIFF_W'(error_in) - DIFF_W'(prev_error_q);
		kd_prod = DPROD_W'(cfg.deriv_gain) * DPROD_W'(diff);
		kd_term = kd_prod >>> GAIN_FRAC_BITS;

		// upper clamp first, then lower: crossed limits settle on the lower one
		acc_sum = ACC_W'(integ_acc_q) + ACC_W'(ki_term);
		acc_hi  = (acc_sum > ACC_W'(cfg.integ_upper)) ? ACC_W'(cfg.integ_upper) : acc_sum;
		acc_lim = (acc_hi < ACC_W'(cfg.integ_lower)) ? ACC_W'(cfg.integ_lower) : acc_hi;

		if (cfg.integ_gain != '0)
			integ_next = acc_lim[LIMIT_WIDTH-1:0];
		else
			integ_next = integ_acc_q;

		total = SUM_W'(kp_term) + SUM_W'(integ_next);
		if (primed_q)
			total = total + SUM_W'(kd_term);

		if (mode == MODE_CLEAR)
			drive_next = '0;
		else
			drive_next = DRIVE_WIDTH'(total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integ_acc_q  <= '0;
			primed_q     <= 1'b0;
		end else if (step) begin
			if (mode == MODE_CLEAR) begin
				prev_error_q <= '0;
				integ_acc_q  <= '0;
				primed_q     <= 1'b0;
			end else begin
				prev_error_q <= error_in;
				integ_acc_q  <= integ_next;
				primed_q     <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/pid_with_clamped_integral.sv
// Top level: PID controller with clamped integral, input and result registers.
//
// Usage:
//   in channel  (in_valid/in_ready): one item = mode + signed error_sample.
//     mode 0 processes the sample, mode 1 clears the controller state.
//   out channel (out_valid/out_ready): one drive value per item, in order.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes gains and
//     integral limits; always ready, unknown indexes are dropped. Write only
//     while no item is in flight.
// Path: an accepted item is held in the input register, and its result is
//   written into the output register when that register is free or being taken.
// Throughput: one item per cycle while out_ready stays high; the integral update (multiply, add, clamp)
//   completes within the cycle in which the item leaves the input register.
// Reset: gains and limits return to their defaults, state clears, both
//   pipeline registers empty.
// Stall: when out_ready is low with a result held, the input register keeps
//   one more item, then in_ready drops until the result is taken.
module pid_with_clamped_integral
	import pwci_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic signed [ERR_WIDTH-1:0]   error_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DRIVE_WIDTH-1:0] drive,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]     cfg_data
);

	pwci_cfg_t                     cfg;
	logic                          valid_s1;
	logic                          mode_s1;
	logic signed [ERR_WIDTH-1:0]   error_s1;
	logic                          out_valid_q;
	logic signed [DRIVE_WIDTH-1:0] drive_q;
	logic signed [DRIVE_WIDTH-1:0] drive_next;
	logic                          advance;

	pwci_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwci_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.mode       (mode_s1),
		.error_in   (error_s1),
		.cfg        (cfg),
		.drive_next (drive_next)
	);

	// item moves from the input register into the result register
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			error_s1 <= error_sample;
		end
		if (advance)
			drive_q <= drive_next;
	end

`ifndef SYNTHESIS
	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_s1 == MODE_CLEAR |=> out_valid && drive == '0)
		else $error("clear item did not produce a zero drive");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
		else $error("input stalled while a register was free");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("advanced item lost before the output register");
`endif

endmodule
